// ----- src/kwtc_pkg.sv -----
// Package with the shared types, constants and automaton tables of the keyword token classifier.
`timescale 1ns / 1ps

package kwtc_pkg;

    localparam int MAX_LEXEME = 63;
    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((MAX_LEXEME < 63) ? MAX_LEXEME : 63);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

    localparam logic [4:0] CLS_ERROR      = 5'd0;
    localparam logic [4:0] CLS_RESERVED   = 5'd1;
    localparam logic [4:0] CLS_BOOLEAN    = 5'd2;
    localparam logic [4:0] CLS_LPAREN     = 5'd3;
    localparam logic [4:0] CLS_RPAREN     = 5'd4;
    localparam logic [4:0] CLS_LBRACE     = 5'd5;
    localparam logic [4:0] CLS_RBRACE     = 5'd6;
    localparam logic [4:0] CLS_COMMA      = 5'd7;
    localparam logic [4:0] CLS_SEMICOLON  = 5'd8;
    localparam logic [4:0] CLS_PLUS       = 5'd9;
    localparam logic [4:0] CLS_MINUS      = 5'd10;
    localparam logic [4:0] CLS_STAR       = 5'd11;
    localparam logic [4:0] CLS_SLASH      = 5'd12;
    localparam logic [4:0] CLS_LT         = 5'd13;
    localparam logic [4:0] CLS_NE         = 5'd14;
    localparam logic [4:0] CLS_LE         = 5'd15;
    localparam logic [4:0] CLS_GT         = 5'd16;
    localparam logic [4:0] CLS_GE         = 5'd17;
    localparam logic [4:0] CLS_ASSIGN     = 5'd18;
    localparam logic [4:0] CLS_EQ         = 5'd19;
    localparam logic [4:0] CLS_IDENTIFIER = 5'd20;
    localparam logic [4:0] CLS_NUMBER     = 5'd21;
    localparam logic [4:0] CLS_COMMENT    = 5'd22;

    typedef enum logic [6:0] {
        S_START, S_ERR, S_NUM, S_IDENT, S_CBODY, S_CSTAR, S_CDONE,
        S_SLASH, S_LT, S_NE, S_LE, S_GT, S_GE, S_ASSIGN, S_EQ,
        S_PLUS, S_MINUS, S_STAR, S_LPAREN, S_RPAREN, S_LBRACE, S_RBRACE,
        S_COMMA, S_SEMICOLON,
        S_P, S_PR, S_PRI, S_PRIN, S_PRINT, S_PRO, S_PROC,
        S_V, S_VO, S_VOI, S_VOID,
        S_W, S_WH, S_WHI, S_WHIL, S_WHILE,
        S_E, S_EL, S_ELS, S_ELSE,
        S_D, S_DO,
        S_B, S_BO, S_BOO, S_BOOL,
        S_I, S_IF, S_IN, S_INT,
        S_S, S_SE, S_SEM, S_SEMI, S_SEMIC,
        S_T, S_TR, S_TRU, S_TRUE,
        S_F, S_FA, S_FAL, S_FALS, S_FALSE
    } scan_state_t;

    typedef struct packed {
        scan_state_t      state;
        logic [LEN_W-1:0] len;
    } tok_entry_t;

    typedef struct packed {
        logic       push;
        tok_entry_t entry;
    } tok_write_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic scan_state_t start_state(input logic [7:0] c);
        scan_state_t nxt;
        nxt = S_ERR;
        if (is_digit(c))
        begin
            nxt = S_NUM;
        end
        else if (c == CHAR_UNDERSCORE)
        begin
            nxt = S_IDENT;
        end
        else
        begin
            case (c)
                "p": nxt = S_P;
                "v": nxt = S_V;
                "w": nxt = S_W;
                "e": nxt = S_E;
                "d": nxt = S_D;
                "b": nxt = S_B;
                "i": nxt = S_I;
                "s": nxt = S_S;
                "t": nxt = S_T;
                "f": nxt = S_F;
                "/": nxt = S_SLASH;
                "<": nxt = S_LT;
                ">": nxt = S_GT;
                "=": nxt = S_ASSIGN;
                "+": nxt = S_PLUS;
                "-": nxt = S_MINUS;
                "*": nxt = S_STAR;
                "(": nxt = S_LPAREN;
                ")": nxt = S_RPAREN;
                "{": nxt = S_LBRACE;
                "}": nxt = S_RBRACE;
                ",": nxt = S_COMMA;
                ";": nxt = S_SEMICOLON;
                default: nxt = S_ERR;
            endcase
        end
        return nxt;
    endfunction

    function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] c);
        scan_state_t nxt;
        nxt = S_ERR;
        case (s)
            S_START:  nxt = start_state(c);
            S_NUM:    nxt = is_digit(c) ? S_NUM : S_ERR;
            S_IDENT:  nxt = is_alpha(c) ? S_IDENT : S_ERR;
            S_CBODY:  nxt = (c == "*") ? S_CSTAR : S_CBODY;
            S_CSTAR:  nxt = (c == "/") ? S_CDONE : ((c == "*") ? S_CSTAR : S_CBODY);
            S_CDONE:  nxt = S_CDONE;
            S_SLASH:  nxt = (c == "*") ? S_CBODY : S_ERR;
            S_LT:     nxt = (c == ">") ? S_NE : ((c == "=") ? S_LE : S_ERR);
            S_GT:     nxt = (c == "=") ? S_GE : S_ERR;
            S_ASSIGN: nxt = (c == "=") ? S_EQ : S_ERR;
            S_P:      nxt = (c == "r") ? S_PR : S_ERR;
            S_PR:     nxt = (c == "i") ? S_PRI : ((c == "o") ? S_PRO : S_ERR);
            S_PRI:    nxt = (c == "n") ? S_PRIN : S_ERR;
            S_PRIN:   nxt = (c == "t") ? S_PRINT : S_ERR;
            S_PRO:    nxt = (c == "c") ? S_PROC : S_ERR;
            S_V:      nxt = (c == "o") ? S_VO : S_ERR;
            S_VO:     nxt = (c == "i") ? S_VOI : S_ERR;
            S_VOI:    nxt = (c == "d") ? S_VOID : S_ERR;
            S_W:      nxt = (c == "h") ? S_WH : S_ERR;
            S_WH:     nxt = (c == "i") ? S_WHI : S_ERR;
            S_WHI:    nxt = (c == "l") ? S_WHIL : S_ERR;
            S_WHIL:   nxt = (c == "e") ? S_WHILE : S_ERR;
            S_E:      nxt = (c == "l") ? S_EL : S_ERR;
            S_EL:     nxt = (c == "s") ? S_ELS : S_ERR;
            S_ELS:    nxt = (c == "e") ? S_ELSE : S_ERR;
            S_D:      nxt = (c == "o") ? S_DO : S_ERR;
            S_B:      nxt = (c == "o") ? S_BO : S_ERR;
            S_BO:     nxt = (c == "o") ? S_BOO : S_ERR;
            S_BOO:    nxt = (c == "l") ? S_BOOL : S_ERR;
            S_I:      nxt = (c == "f") ? S_IF : ((c == "n") ? S_IN : S_ERR);
            S_IN:     nxt = (c == "t") ? S_INT : S_ERR;
            S_S:      nxt = (c == "e") ? S_SE : S_ERR;
            S_SE:     nxt = (c == "m") ? S_SEM : S_ERR;
            S_SEM:    nxt = (c == "i") ? S_SEMI : S_ERR;
            S_SEMI:   nxt = (c == "c") ? S_SEMIC : S_ERR;
            S_T:      nxt = (c == "r") ? S_TR : S_ERR;
            S_TR:     nxt = (c == "u") ? S_TRU : S_ERR;
            S_TRU:    nxt = (c == "e") ? S_TRUE : S_ERR;
            S_F:      nxt = (c == "a") ? S_FA : S_ERR;
            S_FA:     nxt = (c == "l") ? S_FAL : S_ERR;
            S_FAL:    nxt = (c == "s") ? S_FALS : S_ERR;
            S_FALS:   nxt = (c == "e") ? S_FALSE : S_ERR;
            default:  nxt = S_ERR;
        endcase
        return nxt;
    endfunction

    function automatic logic [4:0] final_class(input scan_state_t s);
        logic [4:0] cls;
        case (s)
            S_NUM:       cls = CLS_NUMBER;
            S_IDENT:     cls = CLS_IDENTIFIER;
            S_CDONE:     cls = CLS_COMMENT;
            S_SLASH:     cls = CLS_SLASH;
            S_LT:        cls = CLS_LT;
            S_NE:        cls = CLS_NE;
            S_LE:        cls = CLS_LE;
            S_GT:        cls = CLS_GT;
            S_GE:        cls = CLS_GE;
            S_ASSIGN:    cls = CLS_ASSIGN;
            S_EQ:        cls = CLS_EQ;
            S_PLUS:      cls = CLS_PLUS;
            S_MINUS:     cls = CLS_MINUS;
            S_STAR:      cls = CLS_STAR;
            S_LPAREN:    cls = CLS_LPAREN;
            S_RPAREN:    cls = CLS_RPAREN;
            S_LBRACE:    cls = CLS_LBRACE;
            S_RBRACE:    cls = CLS_RBRACE;
            S_COMMA:     cls = CLS_COMMA;
            S_SEMICOLON: cls = CLS_SEMICOLON;
            S_PRINT, S_PROC, S_VOID, S_WHILE, S_ELSE, S_DO, S_BOOL,
            S_IF, S_INT, S_SEMIC:
                         cls = CLS_RESERVED;
            S_TRUE, S_FALSE:
                         cls = CLS_BOOLEAN;
            default:     cls = CLS_ERROR;
        endcase
        return cls;
    endfunction

endpackage

// ----- src/keyword_token_classifier.sv -----
// Top level of the keyword token classifier.
`timescale 1ns / 1ps

// The block reads a text stream one byte per transfer and reports one result per
// space-delimited lexeme: its token class and its length, saturating at 63.
// Input channel: a byte transfers on a clock edge with push high and full low.
// Output channel: while empty is low the oldest result is on token_class and
// lexeme_length; it transfers on a clock edge with pop high.
// Throughput is one byte per cycle while full is low; the automaton step and
// the length count finish in the cycle the byte transfers.
// A result is written into the queue at the edge at which the space that ends
// its lexeme transfers, and moves on into the output register when that is free.
// A four-entry queue sits between the automaton and the output register, so
// bytes keep flowing while the consumer stalls; full rises when that queue
// holds four results.
// Reset clears the automaton to its start state, the length count, the queue
// and the valid flag of the output register; no result is pending after reset.

module keyword_token_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] token_class,
    output logic [5:0] lexeme_length
);

    import kwtc_pkg::*;

    tok_write_t wr;
    tok_entry_t rd_entry;
    logic       rd;
    logic       q_full;
    logic       q_empty;
    logic       accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    kwtc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (char_in),
        .wr      (wr)
    );

    kwtc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd       (rd),
        .rd_entry (rd_entry),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    kwtc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_entry      (rd_entry),
        .q_empty       (q_empty),
        .rd            (rd),
        .pop           (pop),
        .empty         (empty),
        .token_class   (token_class),
        .lexeme_length (lexeme_length)
    );

endmodule

// ----- src/kwtc_front.sv -----
// Front end: accepts text bytes, runs the lexeme automaton and counts lexeme length.
`timescale 1ns / 1ps

module kwtc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_in,
    output kwtc_pkg::tok_write_t wr
);

    import kwtc_pkg::*;

    scan_state_t      state_reg;
    scan_state_t      state_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_inc;
    logic             is_space;
    logic             comment_open;

    assign is_space     = (char_in == CHAR_SPACE);
    assign comment_open = (state_reg == S_CBODY) || (state_reg == S_CSTAR);
    assign len_inc      = (len_reg < LEN_CAP) ? len_reg + LEN_W'(1) : len_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        if (accept)
        begin
            if (is_space)
            begin
                if (comment_open)
                begin
                    state_next = S_CBODY;
                    len_next   = len_inc;
                end
                else if (state_reg != S_START)
                begin
                    state_next = S_START;
                    len_next   = '0;
                end
            end
            else
            begin
                state_next = next_state(state_reg, char_in);
                len_next   = len_inc;
            end
        end
    end

    always_comb
    begin
        wr.push        = accept && is_space && !comment_open && (state_reg != S_START);
        wr.entry.state = state_reg;
        wr.entry.len   = len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- src/kwtc_queue.sv -----
// Short queue of finished lexemes between the front end and the result stage.
`timescale 1ns / 1ps

module kwtc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kwtc_pkg::tok_write_t wr,
    input  logic                 rd,
    output kwtc_pkg::tok_entry_t rd_entry,
    output logic                 q_full,
    output logic                 q_empty
);

    import kwtc_pkg::*;

    tok_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign do_wr    = wr.push && !q_full;
    assign do_rd    = rd && !q_empty;
    assign rd_entry = mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- src/kwtc_back.sv -----
// Back end: maps each finished lexeme to its class and holds the result for the consumer.
`timescale 1ns / 1ps

module kwtc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kwtc_pkg::tok_entry_t rd_entry,
    input  logic                 q_empty,
    output logic                 rd,
    input  logic                 pop,
    output logic                 empty,
    output logic [4:0]           token_class,
    output logic [5:0]           lexeme_length
);

    import kwtc_pkg::*;

    logic             valid_reg;
    logic [4:0]       class_reg;
    logic [LEN_W-1:0] len_reg;
    logic             slot_free;

    assign slot_free     = !valid_reg || pop;
    assign rd            = slot_free && !q_empty;
    assign empty         = !valid_reg;
    assign token_class   = class_reg;
    assign lexeme_length = len_reg;

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            class_reg <= final_class(rd_entry.state);
            len_reg   <= rd_entry.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= !q_empty;
        end
    end

endmodule

// ----- tb/sv/token_checker.sv -----
// Checker that predicts the token stream of the keyword token classifier and compares each result.
`timescale 1ns / 1ps

module token_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] char_in,
    input  logic       empty,
    input  logic       pop,
    input  logic [4:0] token_class,
    input  logic [5:0] lexeme_length,
    output int         errors,
    output int         pending
);
    import kwtc_pkg::*;

    typedef struct packed {
        logic [4:0] cls;
        logic [5:0] len;
    } token_t;

    token_t     token_q[$];
    logic [7:0] lex_bytes[$];
    int         err_count;

    function automatic bit is_text(input string s);
        bit same;
        int i;
        same = (lex_bytes.size() == s.len());
        for (i = 0; same && i < s.len(); i++)
        begin
            same = (lex_bytes[i] == s[i]);
        end
        return same;
    endfunction

    function automatic bit comment_prefix();
        return (lex_bytes.size() >= 2) && (lex_bytes[0] == "/") && (lex_bytes[1] == "*");
    endfunction

    // The closing pair may not overlap the opening pair.
    function automatic bit comment_closed();
        bit found;
        int i;
        found = 0;
        for (i = 2; i + 1 < lex_bytes.size(); i++)
        begin
            if (lex_bytes[i] == "*" && lex_bytes[i + 1] == "/")
            begin
                found = 1;
            end
        end
        return found;
    endfunction

    function automatic logic [4:0] lexeme_class();
        bit ok;
        int i;
        if (comment_prefix())
        begin
            return CLS_COMMENT;
        end
        ok = 1;
        for (i = 0; i < lex_bytes.size(); i++)
        begin
            ok = ok && (lex_bytes[i] >= "0") && (lex_bytes[i] <= "9");
        end
        if (ok)
        begin
            return CLS_NUMBER;
        end
        if (lex_bytes[0] == CHAR_UNDERSCORE)
        begin
            ok = 1;
            for (i = 1; i < lex_bytes.size(); i++)
            begin
                ok = ok && (((lex_bytes[i] >= "a") && (lex_bytes[i] <= "z")) ||
                            ((lex_bytes[i] >= "A") && (lex_bytes[i] <= "Z")));
            end
            if (ok)
            begin
                return CLS_IDENTIFIER;
            end
        end
        if (is_text("print") || is_text("proc") || is_text("void") || is_text("while") ||
            is_text("else") || is_text("do") || is_text("bool") || is_text("if") ||
            is_text("int") || is_text("semic"))
        begin
            return CLS_RESERVED;
        end
        if (is_text("true") || is_text("false"))
        begin
            return CLS_BOOLEAN;
        end
        if (is_text("("))  return CLS_LPAREN;
        if (is_text(")"))  return CLS_RPAREN;
        if (is_text("{"))  return CLS_LBRACE;
        if (is_text("}"))  return CLS_RBRACE;
        if (is_text(","))  return CLS_COMMA;
        if (is_text(";"))  return CLS_SEMICOLON;
        if (is_text("+"))  return CLS_PLUS;
        if (is_text("-"))  return CLS_MINUS;
        if (is_text("*"))  return CLS_STAR;
        if (is_text("/"))  return CLS_SLASH;
        if (is_text("<"))  return CLS_LT;
        if (is_text("<>")) return CLS_NE;
        if (is_text("<=")) return CLS_LE;
        if (is_text(">"))  return CLS_GT;
        if (is_text(">=")) return CLS_GE;
        if (is_text("="))  return CLS_ASSIGN;
        if (is_text("==")) return CLS_EQ;
        return CLS_ERROR;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_t t;
        if (!rst_n)
        begin
            lex_bytes.delete();
            token_q.delete();
            err_count = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                if (char_in != CHAR_SPACE)
                begin
                    lex_bytes.push_back(char_in);
                end
                else if (lex_bytes.size() != 0)
                begin
                    if (comment_prefix() && !comment_closed())
                    begin
                        lex_bytes.push_back(char_in);
                    end
                    else
                    begin
                        t.cls = lexeme_class();
                        t.len = (lex_bytes.size() > LEN_CAP) ? LEN_CAP : LEN_W'(lex_bytes.size());
                        token_q.push_back(t);
                        lex_bytes.delete();
                    end
                end
            end
            if (pop && !empty)
            begin
                if (token_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer, actual class %0d length %0d",
                             $time, token_class, lexeme_length);
                    err_count++;
                end
                else
                begin
                    t = token_q.pop_front();
                    if (token_class !== t.cls)
                    begin
                        $display("%0t: token_class expected %0d actual %0d",
                                 $time, t.cls, token_class);
                        err_count++;
                    end
                    if (lexeme_length !== t.len)
                    begin
                        $display("%0t: lexeme_length expected %0d actual %0d",
                                 $time, t.len, lexeme_length);
                        err_count++;
                    end
                end
            end
            errors <= err_count;
            pending <= token_q.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the keyword token classifier testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import kwtc_pkg::*;

    typedef enum int {POP_ALWAYS, POP_HALF, POP_RARE, POP_PATTERN} pop_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] char_in = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [4:0] token_class;
    logic [5:0] lexeme_length;
    int         errors;
    int         pending;

    int burst_left = 0;
    int bytes_sent = 0;

    string words[12] = '{"print", "proc", "void", "while", "else", "do", "bool", "if",
                         "int", "semic", "true", "false"};
    string symbols[17] = '{"(", ")", "{", "}", ",", ";", "+", "-", "*", "/", "<", "<>",
                           "<=", ">", ">=", "=", "=="};

    keyword_token_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_in       (char_in),
        .empty         (empty),
        .pop           (pop),
        .token_class   (token_class),
        .lexeme_length (lexeme_length)
    );

    token_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_in       (char_in),
        .empty         (empty),
        .pop           (pop),
        .token_class   (token_class),
        .lexeme_length (lexeme_length),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // The sender works in bursts; the byte stays offered until its transfer.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                push <= 1'b0;
                char_in <= 8'($urandom);
                @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        push <= 1'b1;
        char_in <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] random_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] random_nonspace();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == CHAR_SPACE) ? 8'h21 : b;
    endfunction

    task automatic send_random_lexeme();
        logic [7:0] word[$];
        string      s;
        int         kind;
        int         n;
        int         i;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            s = words[$urandom_range(0, 11)];
            for (i = 0; i < s.len(); i++)
            begin
                word.push_back(s[i]);
            end
            case ($urandom_range(0, 7))
                0: void'(word.pop_back());
                1: word.push_back(random_letter());
                2: word[$urandom_range(0, word.size() - 1)] = random_nonspace();
                default: ;
            endcase
        end
        else if (kind < 45)
        begin
            s = symbols[$urandom_range(0, 16)];
            for (i = 0; i < s.len(); i++)
            begin
                word.push_back(s[i]);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                word.push_back(random_nonspace());
            end
        end
        else if (kind < 55)
        begin
            word.push_back(CHAR_UNDERSCORE);
            n = $urandom_range(0, 7);
            repeat (n) word.push_back(random_letter());
            if ($urandom_range(0, 9) == 0)
            begin
                word.push_back(random_nonspace());
            end
        end
        else if (kind < 65)
        begin
            n = $urandom_range(1, 8);
            repeat (n) word.push_back(8'($urandom_range(48, 57)));
            if ($urandom_range(0, 9) == 0)
            begin
                word.push_back(random_nonspace());
            end
        end
        else if (kind < 77)
        begin
            word.push_back("/");
            word.push_back("*");
            n = $urandom_range(0, 12);
            repeat (n)
            begin
                case ($urandom_range(0, 4))
                    0: word.push_back("*");
                    1: word.push_back("/");
                    2: word.push_back(CHAR_SPACE);
                    3: word.push_back(random_letter());
                    default: word.push_back(8'($urandom));
                endcase
            end
            word.push_back("*");
            word.push_back("/");
            n = $urandom_range(0, 3);
            repeat (n) word.push_back(random_nonspace());
        end
        else if (kind < 95)
        begin
            n = $urandom_range(1, 6);
            repeat (n) word.push_back(random_nonspace());
        end
        else
        begin
            n = $urandom_range(55, 90);
            case ($urandom_range(0, 2))
                0: repeat (n) word.push_back(8'($urandom_range(48, 57)));
                1:
                begin
                    word.push_back(CHAR_UNDERSCORE);
                    repeat (n) word.push_back(random_letter());
                end
                default:
                begin
                    word.push_back("/");
                    word.push_back("*");
                    repeat (n) word.push_back($urandom_range(0, 5) ? random_letter() : CHAR_SPACE);
                    word.push_back("*");
                    word.push_back("/");
                end
            endcase
        end
        foreach (word[i])
        begin
            send_byte(word[i]);
        end
        n = $urandom_range(1, 3);
        repeat (n) send_byte(CHAR_SPACE);
    endtask

    initial
    begin : consumer
        pop_mode_t mode;
        int        mode_left;
        int        hold_left;
        int        cycle_no;
        mode = POP_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        cycle_no = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no == 800 || $urandom_range(0, 2999) == 0)
            begin
                hold_left = $urandom_range(200, 400);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = pop_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    POP_ALWAYS:  pop <= 1'b1;
                    POP_HALF:    pop <= 1'($urandom_range(0, 1));
                    POP_RARE:    pop <= ($urandom_range(0, 7) == 0);
                    POP_PATTERN: pop <= ((cycle_no % 5) < 2);
                    default:     pop <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int waited;
        int i;
        wait (rst_n === 1'b1);
        @(posedge clk);
        send_text("   print proc void while else do bool if int semic true false ");
        send_text("( ) { } , ; + - * / < <> <= > >= = == _ _abXYZ 0123456789 ");
        send_text("/**/ /* a b */ /*/ x*/tail /* * / **/ pri whilee 9a _a1 ");
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h7f);
        send_byte(8'h1f);
        send_byte(CHAR_SPACE);
        for (i = 0; i < 70; i++)
        begin
            send_byte("7");
        end
        send_text(" /*");
        for (i = 0; i < 70; i++)
        begin
            send_byte("x");
        end
        send_text("*/ ");
        while (bytes_sent < 2000)
        begin
            send_random_lexeme();
        end
        push <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/kwtc_pkg.sv
src/kwtc_front.sv
src/kwtc_queue.sv
src/kwtc_back.sv
src/keyword_token_classifier.sv
tb/sv/token_checker.sv
tb/sv/testbench.sv
